[design/gcw_pkg.sv]
// gcw_pkg: shared types, constants and arithmetic helpers for the great circle waypoint block
// fixed-point formats, cordic arctangent steps and the degree-to-turn remainder table
// no dependencies
package gcw_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned CORDIC_STEPS    = 24;

  localparam int unsigned D2T_LANES = 5;
  localparam int unsigned ROT_LANES = 3;
  localparam int unsigned VEC_LANES = 2;

  // degree to turn: v * 2^16 / 360 reduced to a division of v by 45
  localparam logic [25:0] D2T_BIAS = 26'd23592960;   // 45 * 2^19, makes the dividend positive
  localparam logic [26:0] D2T_MUL  = 27'd95443718;   // ceil(2^32 / 45)
  localparam logic [21:0] D2T_QOFS = 22'd524288;     // 2^19, removes the bias from the quotient

  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;
  localparam logic signed [33:0] Z_QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] Z_HALF    = 34'sd2147483648;

  localparam logic signed [24:0] LAT_LIM = 25'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [24:0] LON_LIM = 25'(180 * (1 << ANGLE_FRAC_BITS));

  typedef logic        [31:0] turn_t;
  typedef logic signed [31:0] q_t;
  typedef logic signed [35:0] vw_t;
  typedef logic signed [33:0] rz_t;

  typedef logic [D2T_LANES-1:0][24:0] deg_lanes_t;
  typedef logic [D2T_LANES-1:0][31:0] turn_lanes_t;
  typedef logic [ROT_LANES-1:0][31:0] rot_lanes_t;
  typedef logic [VEC_LANES-1:0][35:0] vec_lanes_t;
  typedef logic [VEC_LANES-1:0][31:0] vec_ang_t;

  // values that ride alongside a cordic chain
  typedef struct packed {
    turn_t t0;
    turn_t t1;
    turn_t t2;
    q_t    q0;
    q_t    q1;
  } side_t;

  typedef logic [63:0][12:0] d2t_tab_t;

  // floor((r * 8192 + 22) / 45) for every remainder r of the division by 45
  function automatic d2t_tab_t build_d2t_tab();
    d2t_tab_t tab;
    for (int r = 0; r < 64; r++) begin
      tab[r] = (r < 45) ? 13'((r * 8192 + 22) / 45) : 13'd0;
    end
    return tab;
  endfunction

  localparam d2t_tab_t D2T_TAB = build_d2t_tab();

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_step(int unsigned i);
    logic [29:0] v;
    case (i)
      0:       v = 30'd536870912;
      1:       v = 30'd316933406;
      2:       v = 30'd167458907;
      3:       v = 30'd85004756;
      4:       v = 30'd42667331;
      5:       v = 30'd21354465;
      6:       v = 30'd10679838;
      7:       v = 30'd5340245;
      8:       v = 30'd2670163;
      9:       v = 30'd1335087;
      10:      v = 30'd667544;
      11:      v = 30'd333772;
      12:      v = 30'd166886;
      13:      v = 30'd83443;
      14:      v = 30'd41722;
      15:      v = 30'd20861;
      16:      v = 30'd10430;
      17:      v = 30'd5215;
      18:      v = 30'd2608;
      19:      v = 30'd1304;
      20:      v = 30'd652;
      21:      v = 30'd326;
      22:      v = 30'd163;
      23:      v = 30'd81;
      24:      v = 30'd41;
      25:      v = 30'd20;
      26:      v = 30'd10;
      27:      v = 30'd5;
      28:      v = 30'd3;
      29:      v = 30'd1;
      30:      v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // q30 product, floored
  function automatic q_t mulq(q_t a, q_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  // magnitude from a vectoring result, x is known non-negative and below 2^33
  function automatic q_t mag_scale(vw_t x);
    logic signed [33:0] xa;
    logic signed [63:0] p;
    xa = {1'b0, x[32:0]};
    p  = xa * GAIN_Q30;
    return p[61:30];
  endfunction

  function automatic vw_t ext_q(q_t v);
    return {{4{v[31]}}, v};
  endfunction

  // signed turn to degrees, rounded half up
  function automatic logic signed [24:0] from_turn(turn_t t);
    logic signed [41:0] p;
    p = $signed(t) * 42'sd360 + (42'sd1 <<< (ANGLE_FRAC_BITS - 1));
    return p[ANGLE_FRAC_BITS+24:ANGLE_FRAC_BITS];
  endfunction

endpackage

[design/gcw_deg2turn.sv]
// gcw_deg2turn: two-stage conversion of degree angles to 32-bit fractions of a turn
// depends on gcw_pkg (lane types, reciprocal constants, remainder table)
module gcw_deg2turn (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  gcw_pkg::deg_lanes_t  deg_i,
  output logic                 vld_o,
  output gcw_pkg::turn_lanes_t turn_o
);

  logic [1:0]                           vld_r;
  logic [gcw_pkg::D2T_LANES-1:0][25:0]  u_r;
  logic [gcw_pkg::D2T_LANES-1:0][25:0]  u_nxt;
  logic [gcw_pkg::D2T_LANES-1:0][20:0]  qq_r;
  logic [gcw_pkg::D2T_LANES-1:0][20:0]  qq_nxt;
  logic [gcw_pkg::D2T_LANES-1:0][31:0]  turn_r;
  logic [gcw_pkg::D2T_LANES-1:0][31:0]  turn_nxt;
  logic [gcw_pkg::D2T_LANES-1:0][52:0]  prod;
  logic [gcw_pkg::D2T_LANES-1:0][25:0]  rem_full;
  logic [gcw_pkg::D2T_LANES-1:0][21:0]  qv;

  // stage one: biased dividend and quotient by 45 through the reciprocal
  always_comb begin
    for (int l = 0; l < gcw_pkg::D2T_LANES; l++) begin
      u_nxt[l]  = {deg_i[l][24], deg_i[l]} + gcw_pkg::D2T_BIAS;
      prod[l]   = 53'(u_nxt[l]) * 53'(gcw_pkg::D2T_MUL);
      qq_nxt[l] = prod[l][52:32];
    end
  end

  // stage two: remainder picks the fraction bits, quotient gives the upper bits
  always_comb begin
    for (int l = 0; l < gcw_pkg::D2T_LANES; l++) begin
      rem_full[l] = u_r[l] - 26'(26'(qq_r[l]) * 26'd45);
      qv[l]       = {1'b0, qq_r[l]} - gcw_pkg::D2T_QOFS;
      turn_nxt[l] = {qv[l][18:0], 13'd0} + 32'(gcw_pkg::D2T_TAB[rem_full[l][5:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      qq_r   <= qq_nxt;
      turn_r <= turn_nxt;
    end
  end

  assign vld_o  = vld_r[1];
  assign turn_o = turn_r;

endmodule

[design/gcw_rot.sv]
// gcw_rot: pipelined rotation cordic, sine and cosine of several turn angles per transaction
// depends on gcw_pkg (types, gain, arctangent steps)
module gcw_rot (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  gcw_pkg::side_t      side_i,
  input  gcw_pkg::rot_lanes_t ang_i,
  output logic                vld_o,
  output gcw_pkg::side_t      side_o,
  output gcw_pkg::rot_lanes_t cos_o,
  output gcw_pkg::rot_lanes_t sin_o
);

  localparam int unsigned N = gcw_pkg::CORDIC_STEPS;
  localparam int unsigned L = gcw_pkg::ROT_LANES;

  logic [N:0]      vld_r;
  gcw_pkg::side_t  side_r [N+1];
  gcw_pkg::q_t     x_r    [N+1][L];
  gcw_pkg::q_t     y_r    [N+1][L];
  gcw_pkg::rz_t    z_r    [N+1][L];
  logic            neg_r  [N+1][L];
  gcw_pkg::rz_t    zs     [L];
  gcw_pkg::rz_t    zf     [L];
  logic            ng     [L];

  // quadrant fold into [-90, 90]
  always_comb begin
    for (int l = 0; l < L; l++) begin
      zs[l] = gcw_pkg::rz_t'($signed(ang_i[l]));
      if (zs[l] > gcw_pkg::Z_QUARTER) begin
        zf[l] = zs[l] - gcw_pkg::Z_HALF;
        ng[l] = 1'b1;
      end else if (zs[l] < -gcw_pkg::Z_QUARTER) begin
        zf[l] = zs[l] + gcw_pkg::Z_HALF;
        ng[l] = 1'b1;
      end else begin
        zf[l] = zs[l];
        ng[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 1; k <= N; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int l = 0; l < L; l++) begin
        x_r[0][l]   <= gcw_pkg::q_t'(gcw_pkg::GAIN_Q30);
        y_r[0][l]   <= '0;
        z_r[0][l]   <= zf[l];
        neg_r[0][l] <= ng[l];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    for (genvar l = 0; l < L; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          neg_r[i+1][l] <= neg_r[i][l];
          if (z_r[i][l] >= 0) begin
            x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] - gcw_pkg::rz_t'({4'd0, gcw_pkg::atan_step(i)});
          end else begin
            x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] + gcw_pkg::rz_t'({4'd0, gcw_pkg::atan_step(i)});
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      cos_o[l] = neg_r[N][l] ? -x_r[N][l] : x_r[N][l];
      sin_o[l] = neg_r[N][l] ? -y_r[N][l] : y_r[N][l];
    end
  end

  assign vld_o  = vld_r[N];
  assign side_o = side_r[N];

endmodule

[design/gcw_vec.sv]
// gcw_vec: pipelined vectoring cordic, angle and unscaled magnitude of several vectors
// depends on gcw_pkg (types, arctangent steps)
module gcw_vec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  gcw_pkg::side_t      side_i,
  input  gcw_pkg::vec_lanes_t vx_i,
  input  gcw_pkg::vec_lanes_t vy_i,
  output logic                vld_o,
  output gcw_pkg::side_t      side_o,
  output gcw_pkg::vec_ang_t   ang_o,
  output gcw_pkg::vec_lanes_t xmag_o
);

  localparam int unsigned N = gcw_pkg::CORDIC_STEPS;
  localparam int unsigned L = gcw_pkg::VEC_LANES;

  logic [N:0]      vld_r;
  gcw_pkg::side_t  side_r [N+1];
  gcw_pkg::vw_t    x_r    [N+1][L];
  gcw_pkg::vw_t    y_r    [N+1][L];
  gcw_pkg::rz_t    z_r    [N+1][L];
  logic            zero_r [N+1][L];
  gcw_pkg::vw_t    xf     [L];
  gcw_pkg::vw_t    yf     [L];
  gcw_pkg::rz_t    zf     [L];
  logic            zr     [L];

  // left half plane folded by half a turn, zero vector flagged
  always_comb begin
    for (int l = 0; l < L; l++) begin
      zr[l] = (vx_i[l] == '0) && (vy_i[l] == '0);
      if (vx_i[l][35]) begin
        xf[l] = -$signed(vx_i[l]);
        yf[l] = -$signed(vy_i[l]);
        zf[l] = gcw_pkg::Z_HALF;
      end else begin
        xf[l] = $signed(vx_i[l]);
        yf[l] = $signed(vy_i[l]);
        zf[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 1; k <= N; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int l = 0; l < L; l++) begin
        x_r[0][l]    <= xf[l];
        y_r[0][l]    <= yf[l];
        z_r[0][l]    <= zf[l];
        zero_r[0][l] <= zr[l];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    for (genvar l = 0; l < L; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          zero_r[i+1][l] <= zero_r[i][l];
          if (y_r[i][l] < 0) begin
            x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] - gcw_pkg::rz_t'({4'd0, gcw_pkg::atan_step(i)});
          end else begin
            x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] + gcw_pkg::rz_t'({4'd0, gcw_pkg::atan_step(i)});
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      ang_o[l]  = zero_r[N][l] ? 32'd0 : z_r[N][l][31:0];
      xmag_o[l] = x_r[N][l];
    end
  end

  assign vld_o  = vld_r[N];
  assign side_o = side_r[N];

endmodule

[design/great_circle_waypoint.sv]
// great_circle_waypoint: point at a given arc distance along the great circle from start to end
// depends on gcw_pkg, gcw_deg2turn, gcw_rot and gcw_vec
//
//  channel  direction  tdata fields, lowest bit first
//  in_      slave      start_lon 25s, start_lat 24s, end_lon 25s, end_lat 24s,
//                      arc_distance 24u, 6 zero bits (128 bits)
//  out_     master     way_lon 25s, way_lat 24s, 7 zero bits (56 bits)
//
// one transaction in per cycle while the output is not stalled, one result per transaction;
// most of the depth comes from eight 25-stage cordic chains in series
// the whole pipe advances together, a stall on the output freezes every stage
// rst_n (synchronous) clears only the valid bits, payload registers hold whatever they had
module great_circle_waypoint (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_lon[24:0] start_lat[48:25] end_lon[73:49] end_lat[97:74] arc_distance[121:98]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // way_lon[24:0] way_lat[48:25]
  output logic [55:0]  out_tdata
);

  // pipe advance: the output register is empty or being taken this cycle
  logic en;

  logic                   out_tvalid_r;
  logic signed [24:0]     out_lon_r;
  logic signed [23:0]     out_lat_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // ---------------- degree to turn ----------------
  gcw_pkg::deg_lanes_t  d_deg;
  gcw_pkg::turn_lanes_t d_turn;
  logic                 d_vld;

  assign d_deg[0] = in_tdata[24:0];
  assign d_deg[1] = {in_tdata[48], in_tdata[48:25]};
  assign d_deg[2] = in_tdata[73:49];
  assign d_deg[3] = {in_tdata[97], in_tdata[97:74]};
  assign d_deg[4] = {1'b0, in_tdata[121:98]};

  gcw_deg2turn u_d2t (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .deg_i  (d_deg),
    .vld_o  (d_vld),
    .turn_o (d_turn)
  );

  // ---------------- sines and cosines of both latitudes and the longitude gap ----------
  gcw_pkg::rot_lanes_t r1_ang, r1_cos, r1_sin;
  gcw_pkg::side_t      r1_side_i, r1_side;
  logic                r1_vld;

  assign r1_ang[0] = d_turn[1];
  assign r1_ang[1] = d_turn[3];
  assign r1_ang[2] = d_turn[2] - d_turn[0];
  assign r1_side_i = '{t0: d_turn[0], t1: d_turn[4], t2: '0, q0: '0, q1: '0};

  gcw_rot u_rot1 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (d_vld), .side_i (r1_side_i),
    .ang_i (r1_ang), .vld_o (r1_vld), .side_o (r1_side), .cos_o (r1_cos), .sin_o (r1_sin)
  );

  // ---------------- azimuth vector, two product stages ----------------
  logic           m1_vld_r;
  gcw_pkg::q_t    m1_p1_r, m1_p2_r, m1_p3_r, m1_cc_r;
  gcw_pkg::side_t m1_side_r;
  logic           m2_vld_r;
  gcw_pkg::vw_t   m2_vx_r, m2_vy_r;
  gcw_pkg::side_t m2_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p1_r   <= gcw_pkg::mulq(r1_cos[0], r1_sin[1]);
      m1_p2_r   <= gcw_pkg::mulq(r1_sin[0], r1_cos[1]);
      m1_p3_r   <= gcw_pkg::mulq(r1_sin[2], r1_cos[1]);
      m1_cc_r   <= r1_cos[2];
      m1_side_r <= '{t0: r1_side.t0, t1: r1_side.t1, t2: '0, q0: r1_sin[0], q1: r1_cos[0]};
      m2_vx_r   <= gcw_pkg::ext_q(m1_p1_r) - gcw_pkg::ext_q(gcw_pkg::mulq(m1_p2_r, m1_cc_r));
      m2_vy_r   <= gcw_pkg::ext_q(m1_p3_r);
      m2_side_r <= m1_side_r;
    end
  end

  // ---------------- azimuth at the start ----------------
  gcw_pkg::vec_lanes_t v1_x, v1_y, v1_mag;
  gcw_pkg::vec_ang_t   v1_ang;
  gcw_pkg::side_t      v1_side;
  logic                v1_vld;

  assign v1_x = {36'd0, m2_vx_r};
  assign v1_y = {36'd0, m2_vy_r};

  gcw_vec u_vec1 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (m2_vld_r), .side_i (m2_side_r),
    .vx_i (v1_x), .vy_i (v1_y), .vld_o (v1_vld), .side_o (v1_side), .ang_o (v1_ang),
    .xmag_o (v1_mag)
  );

  gcw_pkg::rot_lanes_t r2_ang, r2_cos, r2_sin;
  gcw_pkg::side_t      r2_side;
  logic                r2_vld;

  assign r2_ang = {32'd0, 32'd0, v1_ang[0]};

  gcw_rot u_rot2 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (v1_vld), .side_i (v1_side),
    .ang_i (r2_ang), .vld_o (r2_vld), .side_o (r2_side), .cos_o (r2_cos), .sin_o (r2_sin)
  );

  // ---------------- equator crossing: products ----------------
  logic           m3_vld_r;
  gcw_pkg::q_t    m3_caz_r, m3_sa_r, m3_q1_r, m3_q3_r;
  gcw_pkg::side_t m3_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_caz_r  <= r2_cos[0];
      m3_sa_r   <= r2_side.q0;
      m3_q1_r   <= gcw_pkg::mulq(r2_sin[0], r2_side.q0);
      m3_q3_r   <= gcw_pkg::mulq(r2_side.q1, r2_cos[0]);
      m3_side_r <= '{t0: r2_side.t0, t1: r2_side.t1, t2: '0,
                     q0: gcw_pkg::mulq(r2_sin[0], r2_side.q1), q1: '0};
    end
  end

  // lane 0: magnitude for the crossing azimuth, lane 1: arc from crossing to start
  gcw_pkg::vec_lanes_t v2_x, v2_y, v2_mag;
  gcw_pkg::vec_ang_t   v2_ang;
  gcw_pkg::side_t      v2_side;
  logic                v2_vld;

  assign v2_x = {gcw_pkg::ext_q(m3_q3_r), gcw_pkg::ext_q(m3_caz_r)};
  assign v2_y = {gcw_pkg::ext_q(m3_sa_r), gcw_pkg::ext_q(m3_q1_r)};

  gcw_vec u_vec2 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (m3_vld_r), .side_i (m3_side_r),
    .vx_i (v2_x), .vy_i (v2_y), .vld_o (v2_vld), .side_o (v2_side), .ang_o (v2_ang),
    .xmag_o (v2_mag)
  );

  logic           m4_vld_r;
  gcw_pkg::q_t    m4_m_r;
  gcw_pkg::side_t m4_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m4_m_r    <= gcw_pkg::mag_scale(v2_mag[0]);
      m4_side_r <= '{t0: v2_side.t0, t1: v2_ang[1], t2: v2_ang[1] + v2_side.t1,
                     q0: v2_side.q0, q1: '0};
    end
  end

  // ---------------- azimuth at the crossing ----------------
  gcw_pkg::vec_lanes_t v3_x, v3_y, v3_mag;
  gcw_pkg::vec_ang_t   v3_ang;
  gcw_pkg::side_t      v3_side;
  logic                v3_vld;

  assign v3_x = {36'd0, gcw_pkg::ext_q(m4_m_r)};
  assign v3_y = {36'd0, gcw_pkg::ext_q(m4_side_r.q0)};

  gcw_vec u_vec3 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (m4_vld_r), .side_i (m4_side_r),
    .vx_i (v3_x), .vy_i (v3_y), .vld_o (v3_vld), .side_o (v3_side), .ang_o (v3_ang),
    .xmag_o (v3_mag)
  );

  // lanes: crossing azimuth, arc to start, arc to waypoint
  gcw_pkg::rot_lanes_t r3_ang, r3_cos, r3_sin;
  gcw_pkg::side_t      r3_side_i, r3_side;
  logic                r3_vld;

  assign r3_ang    = {v3_side.t2, v3_side.t1, v3_ang[0]};
  assign r3_side_i = '{t0: v3_side.t0, t1: '0, t2: '0, q0: '0, q1: '0};

  gcw_rot u_rot3 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (v3_vld), .side_i (r3_side_i),
    .ang_i (r3_ang), .vld_o (r3_vld), .side_o (r3_side), .cos_o (r3_cos), .sin_o (r3_sin)
  );

  logic           m5_vld_r;
  gcw_pkg::q_t    m5_cdp_r, m5_cd_r, m5_r1_r, m5_r2_r;
  gcw_pkg::side_t m5_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m5_cdp_r  <= r3_cos[1];
      m5_cd_r   <= r3_cos[2];
      m5_r1_r   <= gcw_pkg::mulq(r3_sin[0], r3_sin[1]);
      m5_r2_r   <= gcw_pkg::mulq(r3_sin[0], r3_sin[2]);
      m5_side_r <= '{t0: r3_side.t0, t1: '0, t2: '0,
                     q0: gcw_pkg::mulq(r3_cos[0], r3_sin[2]), q1: '0};
    end
  end

  // lane 0: longitude of the crossing, lane 1: waypoint longitude offset and magnitude
  gcw_pkg::vec_lanes_t v4_x, v4_y, v4_mag;
  gcw_pkg::vec_ang_t   v4_ang;
  gcw_pkg::side_t      v4_side;
  logic                v4_vld;

  assign v4_x = {gcw_pkg::ext_q(m5_cd_r), gcw_pkg::ext_q(m5_cdp_r)};
  assign v4_y = {gcw_pkg::ext_q(m5_r2_r), gcw_pkg::ext_q(m5_r1_r)};

  gcw_vec u_vec4 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (m5_vld_r), .side_i (m5_side_r),
    .vx_i (v4_x), .vy_i (v4_y), .vld_o (v4_vld), .side_o (v4_side), .ang_o (v4_ang),
    .xmag_o (v4_mag)
  );

  logic           m6_vld_r;
  gcw_pkg::q_t    m6_m_r;
  gcw_pkg::side_t m6_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m6_m_r    <= gcw_pkg::mag_scale(v4_mag[1]);
      m6_side_r <= '{t0: v4_side.t0 - v4_ang[0] + v4_ang[1], t1: '0, t2: '0,
                     q0: v4_side.q0, q1: '0};
    end
  end

  // ---------------- waypoint latitude ----------------
  gcw_pkg::vec_lanes_t v5_x, v5_y, v5_mag;
  gcw_pkg::vec_ang_t   v5_ang;
  gcw_pkg::side_t      v5_side;
  logic                v5_vld;

  assign v5_x = {36'd0, gcw_pkg::ext_q(m6_m_r)};
  assign v5_y = {36'd0, gcw_pkg::ext_q(m6_side_r.q0)};

  gcw_vec u_vec5 (
    .clk (clk), .rst_n (rst_n), .en (en), .vld_i (m6_vld_r), .side_i (m6_side_r),
    .vx_i (v5_x), .vy_i (v5_y), .vld_o (v5_vld), .side_o (v5_side), .ang_o (v5_ang),
    .xmag_o (v5_mag)
  );

  // ---------------- turn to degrees, clamp, output register ----------------
  logic               f1_vld_r;
  logic signed [24:0] f1_lat_r, f1_lon_r;
  logic signed [24:0] lat_nxt, lon_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_lat_r <= gcw_pkg::from_turn(v5_ang[0]);
      f1_lon_r <= gcw_pkg::from_turn(v5_side.t0);
    end
  end

  // latitude clamp against rounding overshoot, longitude -180 reported as +180
  always_comb begin
    lat_nxt = f1_lat_r;
    if (f1_lat_r > gcw_pkg::LAT_LIM) begin
      lat_nxt = gcw_pkg::LAT_LIM;
    end else if (f1_lat_r < -gcw_pkg::LAT_LIM) begin
      lat_nxt = -gcw_pkg::LAT_LIM;
    end
    lon_nxt = f1_lon_r;
    if (f1_lon_r <= -gcw_pkg::LON_LIM) begin
      lon_nxt = gcw_pkg::LON_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lat_r <= lat_nxt[23:0];
      out_lon_r <= lon_nxt;
    end
  end

  // valid bits of the stages that sit in this module
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r     <= 1'b0;
      m2_vld_r     <= 1'b0;
      m3_vld_r     <= 1'b0;
      m4_vld_r     <= 1'b0;
      m5_vld_r     <= 1'b0;
      m6_vld_r     <= 1'b0;
      f1_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      m1_vld_r     <= r1_vld;
      m2_vld_r     <= m1_vld_r;
      m3_vld_r     <= r2_vld;
      m4_vld_r     <= v2_vld;
      m5_vld_r     <= r3_vld;
      m6_vld_r     <= v4_vld;
      f1_vld_r     <= v5_vld;
      out_tvalid_r <= f1_vld_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_lat_r, out_lon_r};

  // a held result must freeze the input side
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while a result is held");

  a_lat_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[48:25]) <= gcw_pkg::LAT_LIM &&
                    $signed(out_tdata[48:25]) >= -gcw_pkg::LAT_LIM))
    else $error("waypoint latitude outside [-90, 90]");

  a_lon_half_open : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[24:0]) > -gcw_pkg::LON_LIM))
    else $error("waypoint longitude not in (-180, 180]");

  a_valid_moves_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (en && f1_vld_r) |=> out_tvalid)
    else $error("result lost between the last stage and the output register");

endmodule
